FILE: hw/rtl/mdks_pkg.sv
// mdks_pkg: shared types and constants of the distance-key sorted store
// command and response structs, function and status codes, controller states
// no dependencies
package mdks_pkg;

	localparam int DEF_MAX_ENTRIES = 1024;
	localparam int DEF_COORD_BITS  = 16;
	localparam int DEF_FRAC_BITS   = 8;

	localparam int IDX_W = 10;
	localparam int LEN_W = 25;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_FETCH = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] bx;
		logic signed [15:0] by_coord;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic [LEN_W-1:0] length_fixed;
		logic             is_last;
		logic [1:0]       status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ABS,
		S_SQ,
		S_KEY,
		S_INS_RD,
		S_INS_CMP,
		S_FET_RD,
		S_FET_DATA,
		S_ROOT
	} state_t;

endpackage

FILE: hw/rtl/mdks_root.sv
// mdks_root: iterative square root, one result bit per cycle
// root = floor(sqrt(key * 4^FRAC_BITS)); imports mdks_pkg but uses none of its items
module mdks_root #(
	parameter int KEY_W     = 34,
	parameter int FRAC_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [KEY_W-1:0]                key,
	output logic                            done,
	output logic [KEY_W/2+FRAC_BITS-1:0]    root
);
	import mdks_pkg::*;

	localparam int RW = KEY_W/2 + FRAC_BITS;
	localparam int SW = 2*RW;
	localparam int NW = $clog2(RW+1);

	logic          run_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [RW+2:0] rem_q;
	logic [RW-1:0] root_q;
	logic [SW-1:0] sh_q;

	logic [RW+2:0] rem_sh;
	logic [RW+2:0] trial;
	logic          ge;

	assign rem_sh = {rem_q[RW:0], sh_q[SW-1 -: 2]};
	assign trial  = (RW+3)'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			sh_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sh_q   <= SW'(key) << (2*FRAC_BITS);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= NW'(RW);
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[RW-2:0], ge};
				sh_q   <= sh_q << 2;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hw/rtl/max_distance_key_sorter.sv
// max_distance_key_sorter: sorted store of max squared distance keys
// depends on mdks_pkg and mdks_root
//
//  channel | signals             | transfer
//  --------+---------------------+-------------------------------
//  command | start, busy, cmd    | start high and busy low at clk
//  result  | done, rsp           | done high for one cycle
//
// load: distance math in S_ABS, S_SQ and S_KEY, then for each stored entry moved up
//   one memory read and one write back, and a last write to place the key; busy
//   stays high until the key is placed
// fetch: a memory read in S_FET_RD, root start in S_FET_DATA, KEY_W/2+FRAC_BITS
//   root iterations, then S_ROOT takes the root; done follows in the cycle after
// full load and empty fetch raise done in the cycle after the transfer; clear
//   empties the store at the transfer and leaves busy low
// arst_n empties the store; memory contents need no clearing
// the receiver cannot stall: a result is valid only while done is high
module max_distance_key_sorter #(
	parameter int MAX_ENTRIES = mdks_pkg::DEF_MAX_ENTRIES,
	parameter int COORD_BITS  = mdks_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS   = mdks_pkg::DEF_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mdks_pkg::cmd_t cmd,
	output logic          done,
	output mdks_pkg::rsp_t rsp
);
	import mdks_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CW    = $clog2(MAX_ENTRIES+1);
	localparam int MW    = COORD_BITS + 1;
	localparam int KEY_W = 2*COORD_BITS + 2;
	localparam int ENT_W = KEY_W + IDX_W;
	localparam int RW    = KEY_W/2 + FRAC_BITS;

	state_t state_q, state_d;

	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rp_q;
	logic [CW-1:0] j_q;
	logic [MW-1:0] abs_q [4];
	logic [KEY_W-1:0] sq_q [4];
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic          last_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic [ENT_W-1:0] mem [MAX_ENTRIES];
	logic [ENT_W-1:0] rd_q;

	logic             acc;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic             emit;
	rsp_t             emit_rsp;
	logic             root_start;
	logic             root_done;
	logic [RW-1:0]    root_val;
	logic             ins_done;
	logic             full;
	logic             empty;
	logic [KEY_W-1:0] rd_key;
	logic [ENT_W-1:0] new_ent;

	logic signed [COORD_BITS-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
	logic signed [MW-1:0]         dif [4];
	logic [KEY_W-1:0]             sum1, sum2;

	assign acc    = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign full   = count_q >= CW'(MAX_ENTRIES);
	assign empty  = rp_q >= count_q;
	assign rd_key = rd_q[ENT_W-1 -: KEY_W];
	assign new_ent = {key_q, IDX_W'(count_q)};

	assign ax_c = cmd_q.ax[COORD_BITS-1:0];
	assign ay_c = cmd_q.ay[COORD_BITS-1:0];
	assign bx_c = cmd_q.bx[COORD_BITS-1:0];
	assign by_c = cmd_q.by_coord[COORD_BITS-1:0];
	assign cx_c = cmd_q.cx[COORD_BITS-1:0];
	assign cy_c = cmd_q.cy[COORD_BITS-1:0];

	assign dif[0] = MW'(ax_c) - MW'(bx_c);
	assign dif[1] = MW'(ay_c) - MW'(by_c);
	assign dif[2] = MW'(ax_c) - MW'(cx_c);
	assign dif[3] = MW'(ay_c) - MW'(cy_c);

	assign sum1 = sq_q[0] + sq_q[1];
	assign sum2 = sq_q[2] + sq_q[3];

	mdks_root #(
		.KEY_W     (KEY_W),
		.FRAC_BITS (FRAC_BITS)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.key    (rd_key),
		.done   (root_done),
		.root   (root_val)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (cmd.func == FUNC_LOAD && !full) state_d = S_ABS;
					else if (cmd.func == FUNC_FETCH && !empty) state_d = S_FET_RD;
				end
			end
			S_ABS:      state_d = S_SQ;
			S_SQ:       state_d = S_KEY;
			S_KEY:      state_d = S_INS_RD;
			S_INS_RD:   state_d = (j_q == '0) ? S_IDLE : S_INS_CMP;
			S_INS_CMP:  state_d = (rd_key > key_q) ? S_INS_RD : S_IDLE;
			S_FET_RD:   state_d = S_FET_DATA;
			S_FET_DATA: state_d = S_ROOT;
			S_ROOT:     state_d = root_done ? S_IDLE : S_ROOT;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = j_q[AW-1:0];
		mem_wdata  = new_ent;
		mem_re     = 1'b0;
		mem_raddr  = rp_q[AW-1:0];
		emit       = 1'b0;
		emit_rsp   = '0;
		root_start = 1'b0;
		ins_done   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && cmd.func == FUNC_LOAD && full) begin
					emit            = 1'b1;
					emit_rsp.status = STAT_FULL;
				end else if (acc && cmd.func == FUNC_FETCH && empty) begin
					emit            = 1'b1;
					emit_rsp.status = STAT_EMPTY;
				end
			end
			S_INS_RD: begin
				if (j_q == '0) begin
					mem_we   = 1'b1;
					ins_done = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(j_q - 1'b1);
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (rd_key > key_q) mem_wdata = rd_q;
				else ins_done = 1'b1;
			end
			S_FET_RD:   mem_re = 1'b1;
			S_FET_DATA: root_start = 1'b1;
			S_ROOT: begin
				if (root_done) begin
					emit                  = 1'b1;
					emit_rsp.entry_index  = idx_q;
					emit_rsp.length_fixed = LEN_W'(root_val);
					emit_rsp.is_last      = last_q;
					emit_rsp.status       = STAT_OK;
				end
			end
			default: ;
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rp_q    <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			rsp_q   <= emit_rsp;
			if (acc && cmd.func == FUNC_CLEAR) begin
				count_q <= '0;
				rp_q    <= '0;
			end
			if (ins_done) count_q <= count_q + 1'b1;
			if (state_q == S_FET_DATA) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) cmd_q <= cmd;
		if (state_q == S_ABS) begin
			for (int i = 0; i < 4; i++)
				abs_q[i] <= dif[i][MW-1] ? MW'(-dif[i]) : MW'(dif[i]);
		end
		if (state_q == S_SQ) begin
			for (int i = 0; i < 4; i++)
				sq_q[i] <= abs_q[i] * abs_q[i];
		end
		if (state_q == S_KEY) begin
			key_q <= (sum1 > sum2) ? sum1 : sum2;
			j_q   <= count_q;
		end
		if (state_q == S_INS_CMP && rd_key > key_q) j_q <= j_q - 1'b1;
		if (state_q == S_FET_DATA) begin
			idx_q  <= rd_q[IDX_W-1:0];
			last_q <= (rp_q + 1'b1) == count_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond store depth");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= count_q)
		else $error("read pointer past entry count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.func == FUNC_LOAD && full) |=> (done && rsp.status == STAT_FULL))
		else $error("load into full store not flagged");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transfer");

endmodule
